>>> rtl/core/otb_pkg.sv
// shared types, codes and constants for the one-shot timer bank
package otb_pkg;

  localparam int DEVICES_DEF = 4;

  localparam int DEV_W   = 2;
  localparam int MIN_W   = 16;
  localparam int EPOCH_W = 32;
  localparam int TOT_W   = 22;
  localparam int REM_W   = 23;

  localparam logic [2:0] MODE_START      = 3'd0;
  localparam logic [2:0] MODE_CANCEL     = 3'd1;
  localparam logic [2:0] MODE_CANCEL_ALL = 3'd2;
  localparam logic [2:0] MODE_TICK       = 3'd3;
  localparam logic [2:0] MODE_QUERY      = 3'd4;
  localparam logic [2:0] MODE_RESTORE    = 3'd5;

  localparam logic [TOT_W-1:0]   SEC_PER_MIN    = 22'd60;
  localparam logic [EPOCH_W-1:0] MILLIS_PER_MIN = 32'd60000;
  localparam logic [REM_W-1:0]   REM_MAX        = 23'd4294967;
  // ceil(2^41 / 1000): floor(d / 1000) == (d * RECIP_1000) >> 41 for any 32-bit d
  localparam logic [EPOCH_W-1:0] RECIP_1000     = 32'd2199023256;
  localparam int                 RECIP_SHIFT    = 41;

  // command broadcast to every cell during a walk
  typedef struct packed {
    logic [2:0]         mode;
    logic [DEV_W-1:0]   dev;
    logic               kind;
    logic               ok;
    logic               ready;
    logic [EPOCH_W-1:0] ne;
    logic [EPOCH_W-1:0] nm;
    logic [TOT_W-1:0]   tot;
    logic [EPOCH_W-1:0] de_start;
    logic [EPOCH_W-1:0] dm_start;
    logic [EPOCH_W-1:0] rend;
    logic [TOT_W-1:0]   rtot;
  } cmd_t;

  // what a cell reports while it holds the token; zero otherwise
  typedef struct packed {
    logic               fire;
    logic [DEV_W-1:0]   dev;
    logic               kind;
    logic               hit;
    logic               active;
    logic               eb;
    logic [TOT_W-1:0]   dur;
    logic [EPOCH_W-1:0] de;
    logic [EPOCH_W-1:0] dm;
  } cell_out_t;

endpackage

>>> rtl/core/otb_cell.sv
// one timer entry of the chain: holds its state and passes the walk token on
module otb_cell
  import otb_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      shift,
  input  logic      go,
  input  logic      token_in,
  output logic      token,
  output cell_out_t cell_out
);

  localparam int   DEV_OF  = IDX / 2;
  localparam logic KIND_OF = 1'(IDX % 2);

  logic               active, active_next;
  logic               eb, eb_next;
  logic               pend, pend_next;
  logic [EPOCH_W-1:0] de, de_next;
  logic [EPOCH_W-1:0] dm, dm_next;
  logic [TOT_W-1:0]   dur, dur_next;

  logic paired, addressed, expire, step;

  assign paired    = cmd.ok && ({3'd0, cmd.dev} == 5'(DEV_OF));
  assign addressed = paired && (cmd.kind == KIND_OF);
  assign step      = token && go;

  always_comb begin
    if (pend) begin
      expire = cmd.ready && (de <= cmd.ne);
    end else if (active) begin
      expire = eb ? (cmd.ready && (cmd.ne >= de)) : (cmd.nm >= dm);
    end else begin
      expire = 1'b0;
    end
  end

  always_comb begin
    active_next = active;
    eb_next     = eb;
    pend_next   = pend;
    de_next     = de;
    dm_next     = dm;
    dur_next    = dur;
    if (step) begin
      case (cmd.mode)
        MODE_START: begin
          if (addressed) begin
            active_next = 1'b1;
            dur_next    = cmd.tot;
            pend_next   = 1'b0;
            if (cmd.ne != '0) begin
              eb_next = 1'b1;
              de_next = cmd.de_start;
            end else begin
              eb_next = 1'b0;
              dm_next = cmd.dm_start;
              de_next = '0;
            end
          end
        end
        MODE_CANCEL: begin
          if (addressed) begin
            active_next = 1'b0;
            pend_next   = 1'b0;
          end
        end
        MODE_CANCEL_ALL: begin
          // pending restores survive unless the entry is active
          if (paired && active) begin
            active_next = 1'b0;
            pend_next   = 1'b0;
          end
        end
        MODE_TICK: begin
          if (pend) begin
            if (cmd.ready) begin
              pend_next   = 1'b0;
              active_next = !expire;
            end
          end else if (active && expire) begin
            active_next = 1'b0;
          end
        end
        MODE_RESTORE: begin
          if (addressed) begin
            active_next = 1'b0;
            eb_next     = 1'b1;
            de_next     = cmd.rend;
            dur_next    = cmd.rtot;
            pend_next   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cell_out        = '0;
    cell_out.fire   = token && (cmd.mode == MODE_TICK) && expire;
    cell_out.dev    = cell_out.fire ? DEV_W'(DEV_OF) : '0;
    cell_out.kind   = cell_out.fire ? KIND_OF : 1'b0;
    cell_out.hit    = token && addressed;
    cell_out.active = cell_out.hit && active;
    cell_out.eb     = cell_out.hit && eb;
    cell_out.dur    = cell_out.hit ? dur : '0;
    cell_out.de     = cell_out.hit ? de : '0;
    cell_out.dm     = cell_out.hit ? dm : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token  <= 1'b0;
      active <= 1'b0;
      eb     <= 1'b1;
      pend   <= 1'b0;
      de     <= '0;
      dm     <= '0;
      dur    <= '0;
    end else begin
      if (shift) begin
        token <= token_in;
      end
      active <= active_next;
      eb     <= eb_next;
      pend   <= pend_next;
      de     <= de_next;
      dm     <= dm_next;
      dur    <= dur_next;
    end
  end

endmodule

>>> rtl/core/one_shot_timer_bank.sv
// one-shot timer bank: top level with the walk sequencer and the result register
// every request walks a token along the 2*DEVICES entry cells, one cell per cycle unless
// a fire meets an older held fire and a full result register; tick: walk, then final result
// query: walk, diff, multiply, result; start, cancel, cancel_all, restore: walk only, no result
// a new request is taken only in idle, once the last one is done; stalls if results back up
// synchronous reset clears every entry to inactive, epoch based, zero deadlines
module one_shot_timer_bank
  import otb_pkg::*;
#(
  parameter int DEVICES = DEVICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [DEV_W-1:0]   device_index,
  input  logic               timer_kind,
  input  logic [MIN_W-1:0]   minutes,
  input  logic [EPOCH_W-1:0] now_epoch,
  input  logic               clock_synced,
  input  logic [EPOCH_W-1:0] now_millis,
  input  logic [EPOCH_W-1:0] restore_end_epoch,
  input  logic [TOT_W-1:0]   restore_total_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               fired,
  output logic [DEV_W-1:0]   fired_device,
  output logic               target_on,
  output logic               is_active,
  output logic [TOT_W-1:0]   total_seconds,
  output logic [REM_W-1:0]   remaining_seconds,
  output logic               last
);

  localparam int ENTRIES = 2 * DEVICES;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_DIFF = 5'b00100,
    S_MUL  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state;

  cmd_t      cmd;
  cell_out_t cell_outs [ENTRIES];
  cell_out_t bus;
  logic [ENTRIES-1:0] token;

  logic accept, launch, go, walk_done, slot_free, push_held, push_final;
  logic [MIN_W-1:0] minutes_eff;

  logic             held_valid;
  logic [DEV_W-1:0] held_dev;
  logic             held_on;

  logic               q_active, q_eb;
  logic [TOT_W-1:0]   q_dur;
  logic [EPOCH_W-1:0] q_de, q_dm;
  logic [EPOCH_W-1:0] diff;
  logic               diff_zero;
  logic [63:0]        prod;
  logic [REM_W-1:0]   rem_val;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign launch      = accept;
  assign slot_free   = !out_valid || out_ready;
  assign minutes_eff = (minutes == '0) ? MIN_W'(1) : minutes;

  // a fire with an older fire still held needs the result register
  assign go        = (state == S_WALK) && !(bus.fire && held_valid && !slot_free);
  assign walk_done = go && token[ENTRIES-1];
  assign push_held = go && bus.fire && held_valid;
  assign push_final = (state == S_EMIT) && slot_free;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic tin;
      if (gi == 0) begin : g_head
        assign tin = launch;
      end else begin : g_link
        assign tin = token[gi-1];
      end
      otb_cell #(.IDX(gi)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .shift    (launch || go),
        .go       (go),
        .token_in (tin),
        .token    (token[gi]),
        .cell_out (cell_outs[gi])
      );
    end
  endgenerate

  // only the token holder drives nonzero data
  always_comb begin
    bus = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      bus = cell_out_t'(bus | cell_outs[i]);
    end
  end

  always_comb begin
    if (diff_zero) begin
      rem_val = '0;
    end else if (q_eb) begin
      rem_val = (diff > {9'd0, REM_MAX}) ? REM_MAX : diff[REM_W-1:0];
    end else begin
      rem_val = prod[RECIP_SHIFT+REM_W-1:RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.mode     <= mode;
      cmd.dev      <= device_index;
      cmd.kind     <= timer_kind;
      cmd.ok       <= ({4'd0, device_index} < 6'(DEVICES));
      cmd.ready    <= clock_synced && (now_epoch != '0);
      cmd.ne       <= now_epoch;
      cmd.nm       <= now_millis;
      cmd.tot      <= TOT_W'({6'd0, minutes_eff} * SEC_PER_MIN);
      cmd.de_start <= now_epoch + EPOCH_W'({6'd0, minutes_eff} * SEC_PER_MIN);
      cmd.dm_start <= now_millis + EPOCH_W'({16'd0, minutes_eff} * MILLIS_PER_MIN);
      cmd.rend     <= restore_end_epoch;
      cmd.rtot     <= restore_total_seconds;
    end
  end

  // query capture and remaining-time pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      q_active <= 1'b0;
      q_eb     <= 1'b0;
      q_dur    <= '0;
      q_de     <= '0;
      q_dm     <= '0;
    end else if (go && bus.hit) begin
      q_active <= bus.active;
      q_eb     <= bus.eb;
      q_dur    <= bus.dur;
      q_de     <= bus.de;
      q_dm     <= bus.dm;
    end
    if (state == S_DIFF) begin
      diff      <= q_eb ? (q_de - cmd.ne) : (q_dm - cmd.nm);
      diff_zero <= !q_active || (q_eb ? ((cmd.ne == '0) || (cmd.ne >= q_de))
                                      : (cmd.nm >= q_dm));
    end
    if (state == S_MUL) begin
      prod <= {32'd0, diff} * {32'd0, RECIP_1000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          held_valid <= 1'b0;
          if (accept) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (go && bus.fire) begin
            held_valid <= 1'b1;
          end
          if (walk_done) begin
            if (cmd.mode == MODE_TICK) begin
              state <= S_EMIT;
            end else if (cmd.mode == MODE_QUERY) begin
              state <= S_DIFF;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DIFF: state <= S_MUL;
        S_MUL:  state <= S_EMIT;
        S_EMIT: begin
          if (slot_free) begin
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go && bus.fire) begin
      held_dev <= bus.dev;
      held_on  <= !bus.kind;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_held || push_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_held) begin
      fired             <= 1'b1;
      fired_device      <= held_dev;
      target_on         <= held_on;
      is_active         <= 1'b0;
      total_seconds     <= '0;
      remaining_seconds <= '0;
      last              <= 1'b0;
    end else if (push_final) begin
      last <= 1'b1;
      if (cmd.mode == MODE_QUERY) begin
        fired             <= 1'b0;
        fired_device      <= '0;
        target_on         <= 1'b0;
        is_active         <= q_active;
        total_seconds     <= q_dur;
        remaining_seconds <= rem_val;
      end else begin
        // the fire still held, or an idle result when nothing fired during the tick
        fired             <= held_valid;
        fired_device      <= held_valid ? held_dev : '0;
        target_on         <= held_valid && held_on;
        is_active         <= 1'b0;
        total_seconds     <= '0;
        remaining_seconds <= '0;
      end
    end
  end

  a_token_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(token))
    else $error("more than one cell holds the walk token");

  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (token == '0))
    else $error("request accepted while a walk is in progress");

  a_held_in_tick: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> ((state == S_WALK) || (state == S_EMIT)))
    else $error("held fire outside a tick walk");

  a_walk_launch: assert property (@(posedge clk) disable iff (rst)
    accept |=> token[0])
    else $error("walk did not start at the first cell");

endmodule
